/* sv/i2t_pkg.sv */
// Package for the I2t thermal voltage derating unit.
// Holds the arithmetic constants and register indexes shared by the RTL.
// No dependencies.
`default_nettype none

package i2t_pkg;

	// Configuration register indexes
	localparam logic [7:0] RegResistance = 8'd0;
	localparam logic [7:0] RegContVolt   = 8'd1;
	localparam logic [7:0] RegPeakVolt   = 8'd2;
	localparam logic [7:0] RegTau        = 8'd3;

	// Reset values of the configuration registers
	localparam logic [15:0] ResetResistance = 16'd1000;
	localparam logic [15:0] ResetContVolt   = 16'd3000;
	localparam logic [15:0] ResetPeakVolt   = 16'd6000;
	localparam logic [19:0] ResetTau        = 20'd5000;

	// Time step handling in microseconds
	localparam logic [31:0] DtDefault = 32'd5000;
	localparam logic [31:0] DtMax     = 32'd100000;

	// floor(e^-1 * 2^32)
	localparam logic [31:0] ExpNeg1Q32 = 32'd1580030168;

	// Taylor series length and the largest whole number of time constants
	localparam logic [3:0] SeriesTerms = 4'd13;
	localparam logic [4:0] MaxWhole    = 5'd16;

	// One percent in Q16
	localparam logic [16:0] ActiveThresh = 17'd655;

	// Full load in Q16
	localparam logic [16:0] FullLoad = 17'd65536;

endpackage

`default_nettype wire

/* sv/i2t_thermal_voltage_derating_unit.sv */
// I2t thermal voltage derating unit: one item in, one result out.
// The exponential series is skipped when the step spans more than sixteen time
// constants, and the ratio division loop when the ratio is decided without it. Input is
// not taken while an item is in work or its result waits for the output register; the
// shared 32-step divider and shared 32x32 multiplier are used in turn under one
// sequencer. Reset clears heat and timestamp.
// Depends on i2t_pkg.
`default_nettype none

module i2t_thermal_voltage_derating_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // timestamp_us[31:0], q_voltage_mv[47:32]
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata    // voltage_limit_mv[15:0], trip_ratio_q16[32:16],
	                                         // limiter_active[33], current_est_ma[49:34], zeros
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIV, ST_CUR_END, ST_RATED_END, ST_N_END, ST_F_END,
		ST_TAY_MUL, ST_TAY_DIV, ST_TAY_END, ST_EXP_MUL, ST_EXP_ACC, ST_ROUND,
		ST_SC_HI, ST_SC_LO, ST_SC_ADD, ST_ADD1, ST_ADD2, ST_ADD3,
		ST_THR1, ST_THR2, ST_THR3, ST_RATIO, ST_LIM1, ST_LIM2, ST_LIM3, ST_DONE
	} state_t;

	state_t state_q, ret_q;

	// configuration
	logic [15:0] res_q, cont_q, peak_q;
	logic [19:0] tau_q;

	// persistent state
	logic [31:0] prev_q;
	logic [63:0] heat_q;

	// working registers
	logic [16:0] dt_q;
	logic [15:0] r_q, cur_q, rated_q, lim_q;
	logic [29:0] tau_us_q;
	logic [4:0]  n_q, cnt_q;
	logic [31:0] f_q;
	logic [32:0] term_q, sum_q;
	logic [3:0]  k_q;
	logic [16:0] d_q, ratio_q;
	logic [63:0] acc_q, prod_q, thr_q, rr_q;

	// shared divider
	logic [29:0] div_rem_q, div_den_q;
	logic [31:0] div_quo_q;
	logic [4:0]  div_cnt_q;

	// output register
	logic        m_valid_q;
	logic [55:0] m_data_q;

	// input decode
	logic [31:0] ts;
	logic [15:0] raw;
	logic [16:0] mag;
	logic [31:0] dt_raw;
	logic [15:0] r_eff;
	logic [19:0] tau_eff;
	logic        accept;

	assign ts      = s_axis_tdata[31:0];
	assign raw     = s_axis_tdata[47:32];
	assign mag     = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
	assign dt_raw  = ts - prev_q;
	assign r_eff   = (res_q == 16'd0) ? 16'd1 : res_q;
	assign tau_eff = (tau_q == 20'd0) ? 20'd1 : tau_q;
	assign accept  = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// divider step: shift one dividend bit into the partial remainder
	logic [30:0] div_shift;
	logic        div_ge;
	assign div_shift = {div_rem_q, div_quo_q[31]};
	assign div_ge    = (div_shift >= {1'b0, div_den_q});

	// shared multiplier operand select
	logic [31:0] mul_a, mul_b;
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			ST_TAY_MUL: begin
				mul_a = term_q[31:0];
				mul_b = f_q;
			end
			ST_EXP_MUL: begin
				mul_a = sum_q[31:0];
				mul_b = i2t_pkg::ExpNeg1Q32;
			end
			ST_SC_HI: begin
				mul_a = heat_q[63:32];
				mul_b = 32'(d_q);
			end
			ST_SC_LO: begin
				mul_a = heat_q[31:0];
				mul_b = 32'(d_q);
			end
			ST_ADD1: begin
				mul_a = 32'(cur_q);
				mul_b = 32'(cur_q);
			end
			ST_ADD2: begin
				mul_a = prod_q[31:0];
				mul_b = 32'(dt_q);
			end
			ST_THR1: begin
				mul_a = 32'(rated_q);
				mul_b = 32'(rated_q);
			end
			ST_THR2: begin
				mul_a = prod_q[31:0];
				mul_b = 32'(tau_us_q);
			end
			ST_LIM1: begin
				mul_a = 32'(cont_q);
				mul_b = 32'(ratio_q);
			end
			ST_LIM2: begin
				mul_a = 32'(peak_q);
				mul_b = 32'(i2t_pkg::FullLoad - ratio_q);
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	// helper sums
	logic [64:0] heat_sum;
	logic [63:0] lim_sum;
	logic [33:0] round_sum;
	logic [64:0] rr_shift;
	assign heat_sum  = {1'b0, heat_q} + {1'b0, prod_q};
	assign lim_sum   = acc_q + prod_q + 64'd32768;
	assign round_sum = {1'b0, sum_q} + 34'd32768;
	assign rr_shift  = {rr_q, 1'b0};

	// sequencer, datapath registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ret_q     <= ST_IDLE;
			res_q     <= i2t_pkg::ResetResistance;
			cont_q    <= i2t_pkg::ResetContVolt;
			peak_q    <= i2t_pkg::ResetPeakVolt;
			tau_q     <= i2t_pkg::ResetTau;
			prev_q    <= 32'd0;
			heat_q    <= 64'd0;
			m_valid_q <= 1'b0;
		end else begin
			prod_q <= 64'(mul_a) * 64'(mul_b);

			// register writes
			if (cfg_we) begin
				case (cfg_index)
					i2t_pkg::RegResistance: res_q  <= cfg_data[15:0];
					i2t_pkg::RegContVolt:   cont_q <= cfg_data[15:0];
					i2t_pkg::RegPeakVolt:   peak_q <= cfg_data[15:0];
					i2t_pkg::RegTau:        tau_q  <= cfg_data;
					default: ;
				endcase
			end

			// drop the result once taken, unless a new one replaces it
			if (m_valid_q && m_axis_tready && state_q != ST_DONE) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q   <= ts;
						dt_q     <= (dt_raw == 32'd0 || dt_raw > i2t_pkg::DtMax) ?
						            i2t_pkg::DtDefault[16:0] : dt_raw[16:0];
						r_q      <= r_eff;
						tau_us_q <= 30'(tau_eff * 30'd1000);
						// current = |vq| * 1000 / R
						div_rem_q <= 30'd0;
						div_quo_q <= 32'(mag * 27'd1000);
						div_den_q <= 30'(r_eff);
						div_cnt_q <= 5'd0;
						ret_q     <= ST_CUR_END;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_rem_q <= div_ge ? 30'(div_shift - {1'b0, div_den_q}) : div_shift[29:0];
					div_quo_q <= {div_quo_q[30:0], div_ge};
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						state_q <= ret_q;
					end
				end
				ST_CUR_END: begin
					cur_q     <= (div_quo_q > 32'd65535) ? 16'hFFFF : div_quo_q[15:0];
					div_rem_q <= 30'd0;
					div_quo_q <= 32'(cont_q * 26'd1000);
					div_den_q <= 30'(r_q);
					ret_q     <= ST_RATED_END;
					state_q   <= ST_DIV;
				end
				ST_RATED_END: begin
					rated_q   <= (div_quo_q > 32'd65535) ? 16'hFFFF : div_quo_q[15:0];
					div_rem_q <= 30'd0;
					div_quo_q <= 32'(dt_q);
					div_den_q <= tau_us_q;
					ret_q     <= ST_N_END;
					state_q   <= ST_DIV;
				end
				ST_N_END: begin
					if (div_quo_q > 32'(i2t_pkg::MaxWhole)) begin
						sum_q   <= 33'd0;
						state_q <= ST_ROUND;
					end else begin
						// fraction = rem * 2^32 / tau
						n_q       <= div_quo_q[4:0];
						div_quo_q <= 32'd0;
						div_den_q <= tau_us_q;
						ret_q     <= ST_F_END;
						state_q   <= ST_DIV;
					end
				end
				ST_F_END: begin
					f_q     <= div_quo_q;
					term_q  <= 33'h1_0000_0000;
					sum_q   <= 33'h1_0000_0000;
					k_q     <= 4'd1;
					state_q <= ST_TAY_MUL;
				end
				ST_TAY_MUL: begin
					state_q <= ST_TAY_DIV;
				end
				ST_TAY_DIV: begin
					// the first term is exactly one, so its product is f
					div_rem_q <= 30'd0;
					div_quo_q <= term_q[32] ? f_q : prod_q[63:32];
					div_den_q <= 30'(k_q);
					ret_q     <= ST_TAY_END;
					state_q   <= ST_DIV;
				end
				ST_TAY_END: begin
					term_q <= {1'b0, div_quo_q};
					sum_q  <= k_q[0] ? (sum_q - {1'b0, div_quo_q}) : (sum_q + {1'b0, div_quo_q});
					if (k_q == i2t_pkg::SeriesTerms) begin
						cnt_q   <= n_q;
						state_q <= ST_EXP_MUL;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= ST_TAY_MUL;
					end
				end
				ST_EXP_MUL: begin
					state_q <= (cnt_q == 5'd0) ? ST_ROUND : ST_EXP_ACC;
				end
				ST_EXP_ACC: begin
					sum_q   <= sum_q[32] ? {1'b0, i2t_pkg::ExpNeg1Q32} : {1'b0, prod_q[63:32]};
					cnt_q   <= cnt_q - 5'd1;
					state_q <= ST_EXP_MUL;
				end
				ST_ROUND: begin
					d_q     <= round_sum[32:16];
					state_q <= ST_SC_HI;
				end
				ST_SC_HI: begin
					state_q <= ST_SC_LO;
				end
				ST_SC_LO: begin
					acc_q   <= {prod_q[47:0], 16'd0};
					state_q <= ST_SC_ADD;
				end
				ST_SC_ADD: begin
					if (!d_q[16]) begin
						heat_q <= acc_q + {16'd0, prod_q[63:16]};
					end
					state_q <= ST_ADD1;
				end
				ST_ADD1: begin
					state_q <= ST_ADD2;
				end
				ST_ADD2: begin
					state_q <= ST_ADD3;
				end
				ST_ADD3: begin
					// saturate the heat sum
					heat_q  <= heat_sum[64] ? {64{1'b1}} : heat_sum[63:0];
					state_q <= ST_THR1;
				end
				ST_THR1: begin
					state_q <= ST_THR2;
				end
				ST_THR2: begin
					state_q <= ST_THR3;
				end
				ST_THR3: begin
					thr_q   <= prod_q;
					rr_q    <= heat_q;
					cnt_q   <= 5'd16;
					ratio_q <= 17'd0;
					if (prod_q == 64'd0) begin
						ratio_q <= (heat_q != 64'd0) ? i2t_pkg::FullLoad : 17'd0;
						state_q <= ST_LIM1;
					end else if (heat_q >= prod_q) begin
						ratio_q <= i2t_pkg::FullLoad;
						state_q <= ST_LIM1;
					end else begin
						state_q <= ST_RATIO;
					end
				end
				ST_RATIO: begin
					if (rr_shift[63:0] >= thr_q) begin
						rr_q    <= rr_shift[63:0] - thr_q;
						ratio_q <= {ratio_q[15:0], 1'b1};
					end else begin
						rr_q    <= rr_shift[63:0];
						ratio_q <= {ratio_q[15:0], 1'b0};
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						state_q <= ST_LIM1;
					end
				end
				ST_LIM1: begin
					state_q <= ST_LIM2;
				end
				ST_LIM2: begin
					acc_q   <= prod_q;
					state_q <= ST_LIM3;
				end
				ST_LIM3: begin
					lim_q   <= lim_sum[31:16];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {6'd0, cur_q, (ratio_q > i2t_pkg::ActiveThresh),
						              ratio_q, lim_q};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
